>>> sv/u8dec_pkg.sv
// u8dec_pkg: types and byte-class constants for the utf-8 code point decoder
// no dependencies
`timescale 1ns / 1ps

package u8dec_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned CpW   = 21;
    localparam int unsigned LeftW = 2;

    localparam logic [ByteW-1:0] ASCII_LIMIT = 8'h80;
    localparam logic [ByteW-1:0] LEAD2_MASK  = 8'hE0;
    localparam logic [ByteW-1:0] LEAD2_CODE  = 8'hC0;
    localparam logic [ByteW-1:0] LEAD2_BITS  = 8'h1F;
    localparam logic [ByteW-1:0] LEAD3_MASK  = 8'hF0;
    localparam logic [ByteW-1:0] LEAD3_CODE  = 8'hE0;
    localparam logic [ByteW-1:0] LEAD3_BITS  = 8'h0F;
    localparam logic [ByteW-1:0] LEAD4_MASK  = 8'hF8;
    localparam logic [ByteW-1:0] LEAD4_CODE  = 8'hF0;
    localparam logic [ByteW-1:0] LEAD4_BITS  = 8'h07;
    localparam logic [ByteW-1:0] CONT_MASK   = 8'hC0;
    localparam logic [ByteW-1:0] CONT_CODE   = 8'h80;
    localparam logic [ByteW-1:0] CONT_BITS   = 8'h3F;

    localparam logic [LeftW-1:0] LEFT_NONE  = 2'd0;
    localparam logic [LeftW-1:0] LEFT_ONE   = 2'd1;
    localparam logic [LeftW-1:0] LEFT_TWO   = 2'd2;
    localparam logic [LeftW-1:0] LEFT_THREE = 2'd3;

    typedef struct packed {
        logic [LeftW-1:0] bytes_left;
        logic [CpW-1:0]   accumulator;
        logic             seq_broken;
    } dec_state_t;

    typedef struct packed {
        logic [CpW-1:0] code_point;
        logic           has_point;
        logic           end_mark;
    } dec_result_t;

endpackage

>>> sv/u8dec_if.sv
// u8dec_byte_if and u8dec_cp_if: valid/ready channels for bytes and code points
// depends on u8dec_pkg
`timescale 1ns / 1ps

interface u8dec_byte_if
    import u8dec_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [ByteW-1:0] byte_in;
    logic             text_end;

    modport source (output valid, output byte_in, output text_end, input ready);
    modport sink   (input valid, input byte_in, input text_end, output ready);
endinterface

interface u8dec_cp_if
    import u8dec_pkg::*;
;
    logic           valid;
    logic           ready;
    logic [CpW-1:0] code_point;
    logic           has_point;
    logic           end_mark;

    modport source (output valid, output code_point, output has_point, output end_mark,
                    input ready);
    modport sink   (input valid, input code_point, input has_point, input end_mark,
                    output ready);
endinterface

>>> sv/u8dec_step.sv
// u8dec_step: decode one byte against the open sequence, next state and result
// depends on u8dec_pkg
`timescale 1ns / 1ps

module u8dec_step
    import u8dec_pkg::*;
(
    input  dec_state_t       state,
    input  logic [ByteW-1:0] byte_in,
    input  logic             text_end,
    output dec_state_t       state_next,
    output dec_result_t      result,
    output logic             emit
);

    logic [LeftW-1:0] left_dec;
    logic [CpW-1:0]   acc_shift;
    logic             is_cont;
    logic             have;
    logic [CpW-1:0]   cp;

    assign left_dec  = state.bytes_left - LEFT_ONE;
    assign acc_shift = {state.accumulator[CpW-7:0], 6'b0}
                     | CpW'(byte_in & CONT_BITS);
    assign is_cont   = (byte_in & CONT_MASK) == CONT_CODE;

    always_comb
    begin
        state_next = state;
        have       = 1'b0;
        cp         = '0;
        if (state.bytes_left == LEFT_NONE)
        begin
            priority if (byte_in < ASCII_LIMIT)
            begin
                have = 1'b1;
                cp   = CpW'(byte_in);
            end
            else if ((byte_in & LEAD2_MASK) == LEAD2_CODE)
            begin
                state_next.accumulator = CpW'(byte_in & LEAD2_BITS);
                state_next.bytes_left  = LEFT_ONE;
                state_next.seq_broken  = 1'b0;
            end
            else if ((byte_in & LEAD3_MASK) == LEAD3_CODE)
            begin
                state_next.accumulator = CpW'(byte_in & LEAD3_BITS);
                state_next.bytes_left  = LEFT_TWO;
                state_next.seq_broken  = 1'b0;
            end
            else if ((byte_in & LEAD4_MASK) == LEAD4_CODE)
            begin
                state_next.accumulator = CpW'(byte_in & LEAD4_BITS);
                state_next.bytes_left  = LEFT_THREE;
                state_next.seq_broken  = 1'b0;
            end
            else
            begin
                state_next = state;
            end
        end
        else
        begin
            if (is_cont)
            begin
                state_next.accumulator = acc_shift;
            end
            else
            begin
                state_next.seq_broken = 1'b1;
            end
            state_next.bytes_left = left_dec;
            if (left_dec == LEFT_NONE && !state_next.seq_broken)
            begin
                have = 1'b1;
                cp   = state_next.accumulator;
            end
        end
        if (text_end)
        begin
            state_next = '0;
        end
    end

    assign result.code_point = have ? cp : '0;
    assign result.has_point  = have;
    assign result.end_mark   = text_end;
    assign emit              = have | text_end;

endmodule

>>> sv/utf8_codepoint_decoder.sv
// utf8_codepoint_decoder: streaming utf-8 decoder, byte beats in, code point beats out
// path: a byte beat is held in the input register, then its result, if any, in the result register
// throughput: one byte per cycle while the code point channel does not stall, with the next state from u8dec_step
// reset: rst_n clears the sequence state and both valid flags; payload is not reset
// depends on u8dec_pkg, u8dec_if, u8dec_step
`timescale 1ns / 1ps

module utf8_codepoint_decoder
    import u8dec_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    u8dec_byte_if.sink          byte_ch,
    u8dec_cp_if.source          cp_ch
);

    logic             in_valid_reg;
    logic [ByteW-1:0] in_byte_reg;
    logic             in_end_reg;
    dec_state_t       state_reg;
    dec_state_t       state_next;
    dec_result_t      out_reg;
    logic             out_valid_reg;
    dec_result_t      step_result;
    logic             step_emit;
    logic             out_free;
    logic             step_fire;
    logic             in_take;

    u8dec_step u_step (
        .state      (state_reg),
        .byte_in    (in_byte_reg),
        .text_end   (in_end_reg),
        .state_next (state_next),
        .result     (step_result),
        .emit       (step_emit)
    );

    assign out_free      = !out_valid_reg || cp_ch.ready;
    assign step_fire     = in_valid_reg && (!step_emit || out_free);
    assign byte_ch.ready = !in_valid_reg || step_fire;
    assign in_take       = byte_ch.valid && byte_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (byte_ch.ready)
            begin
                in_valid_reg <= byte_ch.valid;
            end
            if (step_fire)
            begin
                state_reg <= state_next;
            end
            if (out_free)
            begin
                out_valid_reg <= step_fire && step_emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= byte_ch.byte_in;
            in_end_reg  <= byte_ch.text_end;
        end
        if (out_free && step_fire && step_emit)
        begin
            out_reg <= step_result;
        end
    end

    assign cp_ch.valid      = out_valid_reg;
    assign cp_ch.code_point = out_reg.code_point;
    assign cp_ch.has_point  = out_reg.has_point;
    assign cp_ch.end_mark   = out_reg.end_mark;

`ifndef ASSERT_OFF
    a_end_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
        (step_fire && in_end_reg) |=> (state_reg == '0))
        else $error("sequence state not cleared after end of text");

    a_no_point_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.has_point) |-> (out_reg.code_point == '0))
        else $error("code point not zero on a beat without a point");

    a_empty_input_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> byte_ch.ready)
        else $error("input stalled with an empty input register");

    a_silent_beat_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.has_point) |-> out_reg.end_mark)
        else $error("result beat carries neither point nor end mark");
`endif

endmodule
